// ===== hdl/fbpm_pkg.sv =====
// shared types, widths and codes for the fixed block pool manager
package fbpm_pkg;

  localparam int POOL_DEPTH_DEF = 256;

  localparam int SLOT_W    = 8;
  localparam int TAG_W     = 16;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 3;
  localparam int CNT_OUT_W = 9;
  localparam int CTR_W     = 32;
  localparam int MAXB_W    = 9;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 128;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BUFFERS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_TAG    = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_PURGE = 2'd2
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_LIMIT    = 3'd1,
    ST_CAPACITY = 3'd2,
    ST_OWNER    = 3'd3,
    ST_FULL     = 3'd4
  } stat_t;

  typedef enum logic [2:0] {
    FSM_INIT,
    FSM_IDLE,
    FSM_EXEC,
    FSM_PURGE,
    FSM_PURGE_WAIT,
    FSM_FINISH
  } fsm_t;

  typedef struct packed {
    logic init_wr;
    logic latch;
    logic decide;
    logic purge_step;
    logic report;
  } dp_cmd_t;

  typedef struct packed {
    logic init_last;
    logic is_purge;
    logic idle_empty;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/fixed_block_pool_manager.sv =====
// top level of the fixed block pool manager
// allocate, free, unused codes: decided and reported in EXEC; purge: a PURGE and a PURGE_WAIT
// step per idle slot, reported from FINISH (from EXEC if none). EXEC and FINISH wait while an
// untaken result is held in the output register; the next request is accepted meanwhile
// reset (rst_n low, synchronous) zeroes counters, idle and owned depths; then a fill pass
// writes every slot index to the spare stack (depth POOL_DEPTH) before any request is taken
module fixed_block_pool_manager #(
  parameter int POOL_DEPTH = fbpm_pkg::POOL_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tdata: slot_index [7:0], owner_tag [23:8]
  input  logic [fbpm_pkg::IN_TDATA_W-1:0]      in_tdata,
  // tuser: req_type [1:0]
  input  logic [fbpm_pkg::IN_TUSER_W-1:0]      in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata: status [2:0], granted_index [10:3], purged_any [11], owned_count [20:12],
  //        idle_count [29:21], request_total [61:30], limit_hits [93:62],
  //        capacity_misses [125:94], zero fill [127:126]
  output logic [fbpm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [fbpm_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [fbpm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import fbpm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  stat_t              res_status;
  logic [SLOT_W-1:0]    res_granted;
  logic                 res_purged;
  logic [CNT_OUT_W-1:0] res_owned;
  logic [CNT_OUT_W-1:0] res_idle;
  logic [CTR_W-1:0]     res_req_total;
  logic [CTR_W-1:0]     res_limit_hits;
  logic [CTR_W-1:0]     res_cap_misses;

  // sequencer: one request at a time, purge loops over the idle stack
  fbpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // stacks live in memories, depths and counters in flops
  fbpm_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_we              (cfg_we),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata),
    .in_req_type         (in_tuser[REQ_W-1:0]),
    .in_slot_index       (in_tdata[SLOT_W-1:0]),
    .in_owner_tag        (in_tdata[SLOT_W +: TAG_W]),
    .out_valid           (out_tvalid),
    .out_tready          (out_tready),
    .out_status          (res_status),
    .out_granted_index   (res_granted),
    .out_purged_any      (res_purged),
    .out_owned_count     (res_owned),
    .out_idle_count      (res_idle),
    .out_request_total   (res_req_total),
    .out_limit_hits      (res_limit_hits),
    .out_capacity_misses (res_cap_misses)
  );

  // pack result fields, lowest field first
  assign out_tdata = {2'b00, res_cap_misses, res_limit_hits, res_req_total,
                      res_idle, res_owned, res_purged, res_granted, res_status};

endmodule

// ===== hdl/fbpm_ctrl.sv =====
// request sequencer for the fixed block pool manager
module fbpm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  fbpm_pkg::dp_stat_t stat,
  output fbpm_pkg::dp_cmd_t  cmd
);
  import fbpm_pkg::*;

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      FSM_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.init_last) begin
          state_nxt = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (stat.is_purge && !stat.idle_empty) begin
          state_nxt = FSM_PURGE;
        end else if (stat.out_free) begin
          cmd.decide = 1'b1;
          cmd.report = 1'b1;
          state_nxt  = FSM_IDLE;
        end
      end
      FSM_PURGE: begin
        if (stat.idle_empty) begin
          state_nxt = FSM_FINISH;
        end else begin
          cmd.purge_step = 1'b1;
          state_nxt      = FSM_PURGE_WAIT;
        end
      end
      FSM_PURGE_WAIT: begin
        // top of the idle stack moved, let the read register catch up
        state_nxt = FSM_PURGE;
      end
      FSM_FINISH: begin
        if (stat.out_free) begin
          cmd.report = 1'b1;
          state_nxt  = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_INIT;
      end
    endcase
  end

endmodule

// ===== hdl/fbpm_dp.sv =====
// stacks, counters and result register of the fixed block pool manager
module fbpm_dp #(
  parameter int POOL_DEPTH = fbpm_pkg::POOL_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  fbpm_pkg::dp_cmd_t                     cmd,
  output fbpm_pkg::dp_stat_t                    stat,
  input  logic                                  cfg_we,
  input  logic [fbpm_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [fbpm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic [fbpm_pkg::REQ_W-1:0]            in_req_type,
  input  logic [fbpm_pkg::SLOT_W-1:0]           in_slot_index,
  input  logic [fbpm_pkg::TAG_W-1:0]            in_owner_tag,
  output logic                                  out_valid,
  input  logic                                  out_tready,
  output fbpm_pkg::stat_t                       out_status,
  output logic [fbpm_pkg::SLOT_W-1:0]           out_granted_index,
  output logic                                  out_purged_any,
  output logic [fbpm_pkg::CNT_OUT_W-1:0]        out_owned_count,
  output logic [fbpm_pkg::CNT_OUT_W-1:0]        out_idle_count,
  output logic [fbpm_pkg::CTR_W-1:0]            out_request_total,
  output logic [fbpm_pkg::CTR_W-1:0]            out_limit_hits,
  output logic [fbpm_pkg::CTR_W-1:0]            out_capacity_misses
);
  import fbpm_pkg::*;

  localparam int AW    = $clog2(POOL_DEPTH);
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int CMP_W = (CNT_W > MAXB_W) ? CNT_W : MAXB_W;
  localparam int LAST  = POOL_DEPTH - 1;

  logic [SLOT_W-1:0] spare_mem [POOL_DEPTH];
  logic [SLOT_W-1:0] idle_mem  [POOL_DEPTH];

  logic [AW-1:0]     init_cnt_r;
  logic [CNT_W-1:0]  spare_r, spare_nxt;
  logic [CNT_W-1:0]  idle_r, idle_nxt;
  logic [CNT_W-1:0]  owned_r, owned_nxt;
  logic [CTR_W-1:0]  req_cnt_r, req_cnt_nxt;
  logic [CTR_W-1:0]  lim_cnt_r, lim_cnt_nxt;
  logic [CTR_W-1:0]  cap_cnt_r, cap_cnt_nxt;
  logic              purged_r, purged_nxt;
  logic              out_valid_r;
  logic [MAXB_W-1:0] max_buf_r;
  logic [TAG_W-1:0]  pool_tag_r;

  logic [REQ_W-1:0]  req_r;
  logic [SLOT_W-1:0] slot_r;
  logic [TAG_W-1:0]  tag_r;

  logic [SLOT_W-1:0] idle_rdata_r, spare_rdata_r;
  logic [CNT_W-1:0]  idle_top, spare_top;

  stat_t             status_nxt;
  logic [SLOT_W-1:0] granted_nxt;
  logic              idle_we;
  logic              spare_we;
  logic [AW-1:0]     spare_waddr;
  logic [SLOT_W-1:0] spare_wdata;

  assign idle_top  = idle_r - CNT_W'(1);
  assign spare_top = spare_r - CNT_W'(1);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_buf_r  <= '0;
      pool_tag_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MAX_BUFFERS: max_buf_r  <= cfg_wdata[MAXB_W-1:0];
        CFG_POOL_TAG:    pool_tag_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r  <= in_req_type;
      slot_r <= in_slot_index;
      tag_r  <= in_owner_tag;
    end
  end

  // memories: top of each stack is read every cycle
  always_ff @(posedge clk) begin
    if (idle_we) begin
      idle_mem[idle_r[AW-1:0]] <= slot_r;
    end
    idle_rdata_r <= idle_mem[idle_top[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (spare_we) begin
      spare_mem[spare_waddr] <= spare_wdata;
    end
    spare_rdata_r <= spare_mem[spare_top[AW-1:0]];
  end

  always_comb begin
    spare_we    = cmd.init_wr | cmd.purge_step;
    spare_waddr = cmd.init_wr ? init_cnt_r : spare_r[AW-1:0];
    spare_wdata = cmd.init_wr ? SLOT_W'(init_cnt_r) : idle_rdata_r;
  end

  always_comb begin
    spare_nxt   = spare_r;
    idle_nxt    = idle_r;
    owned_nxt   = owned_r;
    req_cnt_nxt = req_cnt_r;
    lim_cnt_nxt = lim_cnt_r;
    cap_cnt_nxt = cap_cnt_r;
    purged_nxt  = purged_r;
    status_nxt  = ST_OK;
    granted_nxt = '0;
    idle_we     = 1'b0;

    if (cmd.latch) begin
      purged_nxt = 1'b0;
    end

    if (cmd.decide) begin
      case (req_r)
        REQ_ALLOC: begin
          req_cnt_nxt = req_cnt_r + CTR_W'(1);
          if (idle_r != '0) begin
            idle_nxt    = idle_top;
            granted_nxt = idle_rdata_r;
          end else if (max_buf_r != '0 && CMP_W'(owned_r) >= CMP_W'(max_buf_r)) begin
            lim_cnt_nxt = lim_cnt_r + CTR_W'(1);
            status_nxt  = ST_LIMIT;
          end else if (spare_r == '0) begin
            cap_cnt_nxt = cap_cnt_r + CTR_W'(1);
            status_nxt  = ST_CAPACITY;
          end else begin
            spare_nxt   = spare_top;
            granted_nxt = spare_rdata_r;
            owned_nxt   = owned_r + CNT_W'(1);
          end
        end
        REQ_FREE: begin
          if (tag_r != pool_tag_r) begin
            status_nxt = ST_OWNER;
          end else if (idle_r >= owned_r) begin
            status_nxt = ST_FULL;
          end else begin
            idle_we  = 1'b1;
            idle_nxt = idle_r + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end

    if (cmd.purge_step) begin
      idle_nxt   = idle_top;
      spare_nxt  = spare_r + CNT_W'(1);
      owned_nxt  = owned_r - CNT_W'(1);
      purged_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r  <= '0;
      spare_r     <= CNT_W'(POOL_DEPTH);
      idle_r      <= '0;
      owned_r     <= '0;
      req_cnt_r   <= '0;
      lim_cnt_r   <= '0;
      cap_cnt_r   <= '0;
      purged_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.init_wr) begin
        init_cnt_r <= init_cnt_r + AW'(1);
      end
      spare_r   <= spare_nxt;
      idle_r    <= idle_nxt;
      owned_r   <= owned_nxt;
      req_cnt_r <= req_cnt_nxt;
      lim_cnt_r <= lim_cnt_nxt;
      cap_cnt_r <= cap_cnt_nxt;
      purged_r  <= purged_nxt;
      if (cmd.report) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_status          <= status_nxt;
      out_granted_index   <= granted_nxt;
      out_purged_any      <= purged_nxt;
      out_owned_count     <= CNT_OUT_W'(owned_nxt);
      out_idle_count      <= CNT_OUT_W'(idle_nxt);
      out_request_total   <= req_cnt_nxt;
      out_limit_hits      <= lim_cnt_nxt;
      out_capacity_misses <= cap_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    stat.init_last  = (init_cnt_r == AW'(LAST));
    stat.is_purge   = (req_r == REQ_PURGE);
    stat.idle_empty = (idle_r == '0);
    stat.out_free   = !out_valid_r || out_tready;
  end

endmodule

// ===== hdl/fbpm_checker.sv =====
// port-level checks for the fixed block pool manager, bound to the top level
module fbpm_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  // a held result does not change until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // refused requests (status not ok) grant no slot
  a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != 3'd0 |-> out_tdata[10:3] == 8'd0)
    else $error("slot granted on failed request");

  // a purge that returned slots always reports ok
  a_purge_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |-> out_tdata[2:0] == 3'd0 && out_tdata[10:3] == 8'd0)
    else $error("purge result inconsistent");

  // idle slots are always a subset of owned slots
  a_idle_le_owned: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[29:21] <= out_tdata[20:12])
    else $error("idle count above owned count");

  // no request taken in the cycle right after one was taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("back-to-back request accept");

endmodule

bind fixed_block_pool_manager fbpm_checker u_fbpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== test/tb_fixed_block_pool_manager.sv =====
// testbench for the fixed block pool manager: directed and random requests against a predictor
`timescale 1ns / 1ps

module tb_fixed_block_pool_manager;
  import fbpm_pkg::*;

  // code the block must treat as a no-op
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int DEPTH         = POOL_DEPTH_DEF;
  localparam int GAP_PCT       = 23;       // chance of an idle cycle on either side
  localparam int SETTLE_CYCLES = 6;        // extra wait after the last reply, for margin
  localparam int CYCLE_LIMIT   = 400_000;  // generous ceiling for the whole run
  localparam int PRINT_LIMIT   = 100;      // mismatch lines beyond this are only counted

  // one pool reply, laid out exactly like out_tdata[125:0] (status in the low bits)
  typedef struct packed {
    logic [CTR_W-1:0]     capacity_misses;
    logic [CTR_W-1:0]     limit_hits;
    logic [CTR_W-1:0]     request_total;
    logic [CNT_OUT_W-1:0] idle_count;
    logic [CNT_OUT_W-1:0] owned_count;
    logic                 purged_any;
    logic [SLOT_W-1:0]    granted_index;
    logic [STAT_W-1:0]    status;
  } pool_reply_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  // tdata: slot_index [7:0], owner_tag [23:8]
  logic [IN_TDATA_W-1:0]  in_tdata;
  // tuser: req_type [1:0]
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  // tdata: status, granted_index, purged_any, owned_count, idle_count,
  //        request_total, limit_hits, capacity_misses, zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  fixed_block_pool_manager i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // pool state as the block should hold it
  // ---------------------------------------------------------------------------
  logic [SLOT_W-1:0]    spare_slots [DEPTH];
  logic [CNT_OUT_W-1:0] spare_level;
  logic [SLOT_W-1:0]    idle_slots [DEPTH];
  logic [CNT_OUT_W-1:0] idle_level;
  logic [CNT_OUT_W-1:0] owned_level;
  logic [CTR_W-1:0]     alloc_seen;
  logic [CTR_W-1:0]     limit_seen;
  logic [CTR_W-1:0]     capacity_seen;
  logic [MAXB_W-1:0]    max_buffers_reg;
  logic [TAG_W-1:0]     pool_tag_reg;

  // replies still owed by the block, oldest first
  pool_reply_t owed_replies [$];

  // shared knobs between the stimulus and the reply sink
  bit no_gaps     = 1'b0;  // when set, neither side idles
  int hold_cycles = 0;     // receiver refuses replies while this counts down

  int mismatches   = 0;
  int replies_seen = 0;
  int requests_put = 0;
  int status_hits [8];
  int purges_nonempty = 0;
  int cycle_count = 0;

  function automatic void reset_pool_state();
    for (int i = 0; i < DEPTH; i++) begin
      spare_slots[i] = SLOT_W'(i);
      idle_slots[i]  = '0;
    end
    spare_level     = CNT_OUT_W'(DEPTH);
    idle_level      = '0;
    owned_level     = '0;
    alloc_seen      = '0;
    limit_seen      = '0;
    capacity_seen   = '0;
    max_buffers_reg = '0;
    pool_tag_reg    = '0;
  endfunction

  // apply one request to the pool state and return the reply it yields
  function automatic pool_reply_t serve_request(logic [REQ_W-1:0] req, logic [SLOT_W-1:0] slot,
                                                logic [TAG_W-1:0] tag);
    pool_reply_t r;
    r = '0;
    if (req == REQ_ALLOC) begin
      alloc_seen++;
      if (idle_level != 0) begin
        // reuse the most recently released slot
        idle_level--;
        r.granted_index = idle_slots[idle_level];
      end else if (max_buffers_reg != 0 && owned_level >= max_buffers_reg) begin
        // limit is checked ahead of capacity
        limit_seen++;
        r.status = ST_LIMIT;
      end else if (spare_level == 0) begin
        capacity_seen++;
        r.status = ST_CAPACITY;
      end else begin
        spare_level--;
        r.granted_index = spare_slots[spare_level];
        owned_level++;
      end
    end else if (req == REQ_FREE) begin
      if (tag != pool_tag_reg) begin
        r.status = ST_OWNER;
      end else if (idle_level >= owned_level) begin
        r.status = ST_FULL;
      end else begin
        // index pushed as given, no in-use check
        idle_slots[idle_level] = slot;
        idle_level++;
      end
    end else if (req == REQ_PURGE) begin
      while (idle_level != 0 && owned_level != 0 && spare_level < DEPTH) begin
        idle_level--;
        spare_slots[spare_level] = idle_slots[idle_level];
        spare_level++;
        owned_level--;
        r.purged_any = 1'b1;
      end
    end
    r.owned_count     = owned_level;
    r.idle_count      = idle_level;
    r.request_total   = alloc_seen;
    r.limit_hits      = limit_seen;
    r.capacity_misses = capacity_seen;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("[%0t] MISMATCH reply %0d: %s", $time, replies_seen, what);
  endtask

  task automatic check_field(input string name, input logic [CTR_W-1:0] got,
                             input logic [CTR_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // reply sink: ready at random, long holds on request, checks every accepted reply
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_gaps || ($urandom_range(0, 99) >= GAP_PCT);
    end
  end

  pool_reply_t got_reply, want_reply;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_reply = pool_reply_t'(out_tdata[$bits(pool_reply_t)-1:0]);
      if (owed_replies.size() == 0) begin
        report_mismatch("reply with no request outstanding");
      end else begin
        want_reply = owed_replies.pop_front();
        check_field("status", CTR_W'(got_reply.status), CTR_W'(want_reply.status));
        check_field("granted_index", CTR_W'(got_reply.granted_index),
                    CTR_W'(want_reply.granted_index));
        check_field("purged_any", CTR_W'(got_reply.purged_any),
                    CTR_W'(want_reply.purged_any));
        check_field("owned_count", CTR_W'(got_reply.owned_count),
                    CTR_W'(want_reply.owned_count));
        check_field("idle_count", CTR_W'(got_reply.idle_count),
                    CTR_W'(want_reply.idle_count));
        check_field("request_total", got_reply.request_total, want_reply.request_total);
        check_field("limit_hits", got_reply.limit_hits, want_reply.limit_hits);
        check_field("capacity_misses", got_reply.capacity_misses,
                    want_reply.capacity_misses);
        status_hits[want_reply.status]++;
        if (want_reply.purged_any) purges_nonempty++;
      end
      replies_seen++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies still owed", cycle_count,
               owed_replies.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driving helpers
  // ---------------------------------------------------------------------------

  // register write, only issued while the block has nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_MAX_BUFFERS) max_buffers_reg = value[MAXB_W-1:0];
    else pool_tag_reg = value[TAG_W-1:0];
  endtask

  // offer one request, wait for it to be taken, then log the reply it must give;
  // tvalid is left high so back-to-back requests need no extra assignment
  task automatic issue_request(input logic [REQ_W-1:0] req, input logic [SLOT_W-1:0] slot,
                               input logic [TAG_W-1:0] tag, output pool_reply_t reply);
    @(negedge clk);
    while (!no_gaps && $urandom_range(0, 99) < GAP_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {tag, slot};
    do @(posedge clk); while (!in_tready);
    reply = serve_request(req, slot, tag);
    owed_replies.push_back(reply);
    requests_put++;
  endtask

  // stop offering and wait until every owed reply has come back
  task automatic wait_all_replies();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // corner cases one at a time: unused code, empty purge, full/owner rejects,
  // reuse from the idle list, limit reached, unchecked free index, field extremes
  task automatic test_directed();
    pool_reply_t r;
    write_reg(CFG_MAX_BUFFERS, 16'd0);
    write_reg(CFG_POOL_TAG, 16'h0000);
    issue_request(REQ_UNUSED, 8'hFF, 16'hFFFF, r);
    issue_request(REQ_PURGE, 8'h00, 16'h0000, r);   // nothing to purge
    issue_request(REQ_FREE, 8'h00, 16'h0000, r);    // nothing owned, list full
    issue_request(REQ_ALLOC, 8'hFF, 16'hFFFF, r);
    issue_request(REQ_ALLOC, 8'h00, 16'h0000, r);
    issue_request(REQ_FREE, 8'hFF, 16'hFFFF, r);    // wrong owner
    issue_request(REQ_FREE, 8'hFF, 16'h0000, r);
    issue_request(REQ_FREE, 8'h00, 16'h0000, r);    // index never handed out
    issue_request(REQ_FREE, 8'h80, 16'h0000, r);    // list already holds all owned
    issue_request(REQ_ALLOC, 8'h00, 16'h0000, r);   // comes from the idle list
    issue_request(REQ_PURGE, 8'h00, 16'h0000, r);
    issue_request(REQ_ALLOC, 8'h00, 16'h0000, r);
    wait_all_replies();

    // tight limit with an all-ones tag
    write_reg(CFG_MAX_BUFFERS, 16'd1);
    write_reg(CFG_POOL_TAG, 16'hFFFF);
    issue_request(REQ_ALLOC, 8'h00, 16'h0000, r);   // owned already above limit
    issue_request(REQ_FREE, 8'hFF, 16'hFFFF, r);
    issue_request(REQ_ALLOC, 8'h00, 16'h0000, r);   // idle reuse ignores the limit
    issue_request(REQ_FREE, 8'h00, 16'h0000, r);    // wrong owner
    issue_request(REQ_FREE, 8'h00, 16'hFFFF, r);
    issue_request(REQ_FREE, 8'h7F, 16'hFFFF, r);
    issue_request(REQ_PURGE, 8'h00, 16'h0000, r);
    issue_request(REQ_ALLOC, 8'h00, 16'h0000, r);
    issue_request(REQ_ALLOC, 8'h00, 16'h0000, r);   // limit
    issue_request(REQ_UNUSED, 8'h00, 16'h0000, r);
    wait_all_replies();
  endtask

  // take every slot, run out of capacity, then hit a limit equal to the pool depth,
  // hand everything back and purge the whole pool in one go
  task automatic test_capacity_and_top_limit();
    pool_reply_t r;
    logic [SLOT_W-1:0] taken [$];
    int misses;
    int tries;
    misses = 0;
    write_reg(CFG_MAX_BUFFERS, 16'd0);
    write_reg(CFG_POOL_TAG, 16'h5A3C);
    while (misses < 2) begin
      issue_request(REQ_ALLOC, SLOT_W'($urandom), TAG_W'($urandom), r);
      if (r.status == ST_OK) taken.push_back(r.granted_index);
      else if (r.status == ST_CAPACITY) misses++;
    end
    wait_all_replies();

    write_reg(CFG_MAX_BUFFERS, 16'd256);
    issue_request(REQ_ALLOC, 8'h00, 16'h0000, r);   // limit wins over capacity
    issue_request(REQ_FREE, taken[0], pool_tag_reg, r);
    issue_request(REQ_ALLOC, 8'h00, 16'h0000, r);
    foreach (taken[i]) issue_request(REQ_FREE, taken[i], pool_tag_reg, r);
    // top up with arbitrary indices until the free list is full
    tries = 0;
    do begin
      issue_request(REQ_FREE, SLOT_W'($urandom), pool_tag_reg, r);
      tries++;
    end while (r.status != ST_FULL && tries < 2 * DEPTH);
    issue_request(REQ_PURGE, 8'h00, 16'h0000, r);
    wait_all_replies();
  endtask

  // receiver refuses replies for a long stretch while requests keep coming,
  // so the output register fills and the input stalls
  task automatic test_reply_backpressure();
    pool_reply_t r;
    logic [SLOT_W-1:0] taken [$];
    write_reg(CFG_MAX_BUFFERS, 16'd0);
    no_gaps = 1'b1;
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 != 2 || taken.size() == 0) begin
        issue_request(REQ_ALLOC, 8'h00, 16'h0000, r);
        if (r.status == ST_OK) taken.push_back(r.granted_index);
      end else begin
        issue_request(REQ_FREE, taken.pop_front(), pool_tag_reg, r);
      end
    end
    issue_request(REQ_PURGE, 8'h00, 16'h0000, r);
    wait_all_replies();
    no_gaps = 1'b0;
  endtask

  // mostly allocate/free pairs on slots actually handed out, with noise:
  // purges, wrong owners, arbitrary frees and the unused code; one config per phase
  task automatic test_random_traffic();
    pool_reply_t r;
    logic [SLOT_W-1:0] taken [$];
    int roll;
    int pick;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_MAX_BUFFERS, 16'd0);
          write_reg(CFG_POOL_TAG, CFG_DATA_W'($urandom));
        end
        1: begin
          write_reg(CFG_MAX_BUFFERS, 16'd256);
          write_reg(CFG_POOL_TAG, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_MAX_BUFFERS, 16'd1);
          write_reg(CFG_POOL_TAG, 16'h0000);
        end
        3: begin
          // a stretch with no idling on either side
          write_reg(CFG_MAX_BUFFERS, CFG_DATA_W'($urandom_range(2, 16)));
          write_reg(CFG_POOL_TAG, CFG_DATA_W'($urandom));
          no_gaps = 1'b1;
        end
        default: begin
          write_reg(CFG_MAX_BUFFERS, CFG_DATA_W'($urandom_range(17, 255)));
          write_reg(CFG_POOL_TAG, CFG_DATA_W'($urandom));
        end
      endcase
      for (int n = 0; n < 70; n++) begin
        // sender pause until the pipe is empty, mid-phase
        if (n == 35) wait_all_replies();
        roll = $urandom_range(0, 99);
        if (roll < 80 && roll >= 42 && taken.size() != 0) begin
          pick = $urandom_range(0, taken.size() - 1);
          issue_request(REQ_FREE, taken[pick], pool_tag_reg, r);
          taken.delete(pick);
        end else if (roll >= 80 && roll < 85) begin
          issue_request(REQ_PURGE, SLOT_W'($urandom), TAG_W'($urandom), r);
        end else if (roll >= 85 && roll < 90) begin
          issue_request(REQ_FREE, SLOT_W'($urandom),
                        pool_tag_reg ^ TAG_W'($urandom_range(1, 65535)), r);
        end else if (roll >= 90 && roll < 95) begin
          issue_request(REQ_FREE, SLOT_W'($urandom), pool_tag_reg, r);
        end else if (roll >= 95 && roll < 97) begin
          issue_request(REQ_UNUSED, SLOT_W'($urandom), TAG_W'($urandom), r);
        end else begin
          issue_request(REQ_ALLOC, SLOT_W'($urandom), TAG_W'($urandom), r);
          if (r.status == ST_OK) taken.push_back(r.granted_index);
        end
      end
      wait_all_replies();
      no_gaps = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    reset_pool_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // the block fills its spare stack after reset; tready stays low until then

    test_directed();
    test_capacity_and_top_limit();
    test_reply_backpressure();
    test_random_traffic();

    $display("covered %0d requests and %0d replies, %0d purges that handed slots back",
             requests_put, replies_seen, purges_nonempty);
    $display("replies by status: ok %0d, limit %0d, capacity %0d, owner %0d, full %0d",
             status_hits[ST_OK], status_hits[ST_LIMIT], status_hits[ST_CAPACITY],
             status_hits[ST_OWNER], status_hits[ST_FULL]);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
